FILE: rtl/core/ray_triangle_intersect_assert.svh
// Assertion macros for the block's top-level RTL file.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rti_pkg.sv
`default_nettype none
package rti_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int QW     = CW + FB;
    localparam int PW     = 2 * CW - FB;
    localparam int EPSW   = 16;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int ODEPTH = 2;

    localparam logic [EPSW-1:0] EPS_RESET = 16'd66;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RAY  = 1'b1;

    localparam logic [1:0] SLOT_A    = 2'd0;
    localparam logic [1:0] SLOT_B    = 2'd1;
    localparam logic [1:0] SLOT_C    = 2'd2;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW:0] ONE = (CW+1)'(1) << FB;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_vec pos;
        t_vec dir;
        t_vec a;
        t_vec e1;
        t_vec e2;
    } t_ray;

    typedef struct packed {
        logic   valid;
        t_coord det;
        t_coord unum;
        t_coord vnum;
        t_coord tnum;
    } t_dots;

    typedef struct packed {
        logic          valid;
        logic          ok;
        logic [2:0]    neg;
        logic [QW-1:0] qu;
        logic [QW-1:0] qv;
        logic [QW-1:0] qt;
    } t_quot;

    typedef struct packed {
        logic   hit;
        t_coord distance;
    } t_result;

    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            return s[CW] ? CMIN : CMAX;
        end
        return s[CW-1:0];
    endfunction

    function automatic t_coord sat_sub(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} - {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            return s[CW] ? CMIN : CMAX;
        end
        return s[CW-1:0];
    endfunction

    // Product floored to the fixed-point grid, then clamped to the coordinate range.
    function automatic t_coord fmul(input t_coord a, input t_coord b);
        logic signed [2*CW-1:0] p;
        logic signed [PW-1:0]   w;
        logic signed [PW-1:0]   hi_lim;
        logic signed [PW-1:0]   lo_lim;
        p      = a * b;
        w      = $signed(p[2*CW-1:FB]);
        hi_lim = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo_lim = ~hi_lim;
        if (w > hi_lim) begin
            return CMAX;
        end
        if (w < lo_lim) begin
            return CMIN;
        end
        return w[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] mag(input t_coord a);
        return a[CW-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic t_coord from_mag(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        lim = QW'(1) << (CW-1);
        if (neg) begin
            if (q > lim) begin
                return CMIN;
            end
            return ~q[CW-1:0] + 1'b1;
        end
        if (q >= lim) begin
            return CMAX;
        end
        return q[CW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rti_front.sv
`default_nettype none
module rti_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire                  i_op,
    input  wire  [1:0]           i_vertex_slot,
    input  wire  rti_pkg::t_vec  i_pos,
    input  wire  rti_pkg::t_vec  i_dir,
    input  wire                  i_q_pop,
    output logic                 o_q_valid,
    output rti_pkg::t_ray        o_q_data
);
    import rti_pkg::*;

    t_vec             r_va, r_vb, r_vc;
    t_ray             r_q [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             accept, enq;
    t_ray             entry;

    assign full      = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q[r_rd];
    assign accept    = push && !full;
    assign enq       = accept && (i_op == OP_RAY);

    always_comb begin
        entry.pos  = i_pos;
        entry.dir  = i_dir;
        entry.a    = r_va;
        entry.e1.x = sat_sub(r_vb.x, r_va.x);
        entry.e1.y = sat_sub(r_vb.y, r_va.y);
        entry.e1.z = sat_sub(r_vb.z, r_va.z);
        entry.e2.x = sat_sub(r_vc.x, r_va.x);
        entry.e2.y = sat_sub(r_vc.y, r_va.y);
        entry.e2.z = sat_sub(r_vc.z, r_va.z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
            r_vc <= '0;
        end else if (accept && (i_op == OP_LOAD)) begin
            case (i_vertex_slot)
                SLOT_A:  r_va <= i_pos;
                SLOT_B:  r_vb <= i_pos;
                SLOT_C:  r_vc <= i_pos;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(enq) - (QAW+1)'(i_q_pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/rti_geom.sv
`default_nettype none
module rti_geom (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire  rti_pkg::t_ray  i_ray,
    output rti_pkg::t_dots       o_dots
);
    import rti_pkg::*;

    // One multiply per product and stage; sums follow in the next stage.
    logic [4:0] r_vld;
    t_coord     r_m1 [6];
    t_vec       r_s1, r_dir1, r_e11, r_e21;
    t_vec       r_p2, r_s2, r_dir2, r_e12, r_e22;
    t_coord     r_m2 [6];
    t_vec       r_q3, r_dir3, r_e23;
    t_coord     r_md3 [3];
    t_coord     r_mu3 [3];
    t_coord     r_det4, r_un4;
    t_coord     r_mv4 [3];
    t_coord     r_mt4 [3];
    t_coord     r_det5, r_un5, r_vn5, r_tn5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1[0] <= fmul(i_ray.dir.y, i_ray.e2.z);
            r_m1[1] <= fmul(i_ray.dir.z, i_ray.e2.y);
            r_m1[2] <= fmul(i_ray.dir.z, i_ray.e2.x);
            r_m1[3] <= fmul(i_ray.dir.x, i_ray.e2.z);
            r_m1[4] <= fmul(i_ray.dir.x, i_ray.e2.y);
            r_m1[5] <= fmul(i_ray.dir.y, i_ray.e2.x);
            r_s1.x  <= sat_sub(i_ray.pos.x, i_ray.a.x);
            r_s1.y  <= sat_sub(i_ray.pos.y, i_ray.a.y);
            r_s1.z  <= sat_sub(i_ray.pos.z, i_ray.a.z);
            r_dir1  <= i_ray.dir;
            r_e11   <= i_ray.e1;
            r_e21   <= i_ray.e2;

            r_p2.x  <= sat_sub(r_m1[0], r_m1[1]);
            r_p2.y  <= sat_sub(r_m1[2], r_m1[3]);
            r_p2.z  <= sat_sub(r_m1[4], r_m1[5]);
            r_m2[0] <= fmul(r_s1.y, r_e11.z);
            r_m2[1] <= fmul(r_s1.z, r_e11.y);
            r_m2[2] <= fmul(r_s1.z, r_e11.x);
            r_m2[3] <= fmul(r_s1.x, r_e11.z);
            r_m2[4] <= fmul(r_s1.x, r_e11.y);
            r_m2[5] <= fmul(r_s1.y, r_e11.x);
            r_s2    <= r_s1;
            r_dir2  <= r_dir1;
            r_e12   <= r_e11;
            r_e22   <= r_e21;

            r_q3.x   <= sat_sub(r_m2[0], r_m2[1]);
            r_q3.y   <= sat_sub(r_m2[2], r_m2[3]);
            r_q3.z   <= sat_sub(r_m2[4], r_m2[5]);
            r_md3[0] <= fmul(r_e12.x, r_p2.x);
            r_md3[1] <= fmul(r_e12.y, r_p2.y);
            r_md3[2] <= fmul(r_e12.z, r_p2.z);
            r_mu3[0] <= fmul(r_s2.x, r_p2.x);
            r_mu3[1] <= fmul(r_s2.y, r_p2.y);
            r_mu3[2] <= fmul(r_s2.z, r_p2.z);
            r_dir3   <= r_dir2;
            r_e23    <= r_e22;

            r_det4   <= sat_add(sat_add(r_md3[0], r_md3[1]), r_md3[2]);
            r_un4    <= sat_add(sat_add(r_mu3[0], r_mu3[1]), r_mu3[2]);
            r_mv4[0] <= fmul(r_dir3.x, r_q3.x);
            r_mv4[1] <= fmul(r_dir3.y, r_q3.y);
            r_mv4[2] <= fmul(r_dir3.z, r_q3.z);
            r_mt4[0] <= fmul(r_e23.x, r_q3.x);
            r_mt4[1] <= fmul(r_e23.y, r_q3.y);
            r_mt4[2] <= fmul(r_e23.z, r_q3.z);

            r_det5 <= r_det4;
            r_un5  <= r_un4;
            r_vn5  <= sat_add(sat_add(r_mv4[0], r_mv4[1]), r_mv4[2]);
            r_tn5  <= sat_add(sat_add(r_mt4[0], r_mt4[1]), r_mt4[2]);
        end
    end

    always_comb begin
        o_dots.valid = r_vld[4];
        o_dots.det   = r_det5;
        o_dots.unum  = r_un5;
        o_dots.vnum  = r_vn5;
        o_dots.tnum  = r_tn5;
    end

endmodule
`default_nettype wire

FILE: rtl/core/rti_div.sv
`default_nettype none
module rti_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire  [rti_pkg::EPSW-1:0]    i_eps,
    input  wire  rti_pkg::t_dots        i_dots,
    output rti_pkg::t_quot              o_quot
);
    import rti_pkg::*;

    // Restoring divider, one quotient bit per stage. Each lane shifts its dividend
    // out of the top of r_sh while the quotient bits enter at the bottom.
    logic          r_vld [QW+1];
    logic          r_ok  [QW+1];
    logic [2:0]    r_neg [QW+1];
    logic [CW-1:0] r_md  [QW+1];
    logic [QW-1:0] r_sh  [QW+1][3];
    logic [CW-1:0] r_rem [QW+1][3];

    logic [CW-1:0] n_rem [QW][3];
    logic [QW-1:0] n_sh  [QW][3];
    t_coord        num   [3];
    logic [CW:0]   trial, diff;

    assign num[0] = i_dots.unum;
    assign num[1] = i_dots.vnum;
    assign num[2] = i_dots.tnum;

    always_comb begin
        trial = '0;
        diff  = '0;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial = {r_rem[k][l], r_sh[k][l][QW-1]};
                diff  = trial - {1'b0, r_md[k]};
                if (!diff[CW]) begin
                    n_rem[k][l] = diff[CW-1:0];
                    n_sh[k][l]  = {r_sh[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = trial[CW-1:0];
                    n_sh[k][l]  = {r_sh[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_dots.valid;
            for (int k = 0; k < QW; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok[0] <= (mag(i_dots.det) > {{(CW-EPSW){1'b0}}, i_eps});
            r_md[0] <= mag(i_dots.det);
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= num[l][CW-1] ^ i_dots.det[CW-1];
                r_sh[0][l]  <= {mag(num[l]), {FB{1'b0}}};
                r_rem[0][l] <= '0;
            end
            for (int k = 0; k < QW; k++) begin
                r_ok[k+1]  <= r_ok[k];
                r_md[k+1]  <= r_md[k];
                r_neg[k+1] <= r_neg[k];
                for (int l = 0; l < 3; l++) begin
                    r_sh[k+1][l]  <= n_sh[k][l];
                    r_rem[k+1][l] <= n_rem[k][l];
                end
            end
        end
    end

    always_comb begin
        o_quot.valid = r_vld[QW];
        o_quot.ok    = r_ok[QW];
        o_quot.neg   = r_neg[QW];
        o_quot.qu    = r_sh[QW][0];
        o_quot.qv    = r_sh[QW][1];
        o_quot.qt    = r_sh[QW][2];
    end

endmodule
`default_nettype wire

FILE: rtl/core/ray_triangle_intersect.sv
// Ray-triangle intersection, Moller-Trumbore, signed Q16.16.
// Input channel: an item is transferred when push is high and full is low.
// Op 0 loads vertex a, b or c (vertex_slot) from the pos fields and gives no result;
// op 1 tests a ray (origin pos, direction dir) against the stored triangle.
// A load takes effect for every ray transferred after it.
// Result channel: while empty is low, hit and distance show the oldest result;
// it is transferred when pop is high. A miss reports distance zero.
// Configuration: det_epsilon is written when i_cfg_valid is high; o_cfg_ready is
// always high. Write it only while no ray is in flight.
// Throughput: one ray per cycle while the pipeline is not holding. A ray passes from
// transfer to empty going low through the front queue, five multiply and sum stages,
// one divider entry stage, 48 divider stages of one quotient bit each, and the result
// buffer. When pop stays low the pipeline holds once the two-entry result buffer
// fills; the four-entry front queue then fills and full rises.
// Reset clears the vertices to zero, det_epsilon to 66 and drops all items in flight.
`default_nettype none
module ray_triangle_intersect (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire                          i_op,
    input  wire  [1:0]                   i_vertex_slot,
    input  wire  signed [31:0]           i_pos_x,
    input  wire  signed [31:0]           i_pos_y,
    input  wire  signed [31:0]           i_pos_z,
    input  wire  signed [31:0]           i_dir_x,
    input  wire  signed [31:0]           i_dir_y,
    input  wire  signed [31:0]           i_dir_z,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [rti_pkg::EPSW-1:0]     i_cfg_det_epsilon,
    output logic                         empty,
    input  wire                          pop,
    output logic                         o_hit,
    output logic signed [31:0]           o_distance
);
    import rti_pkg::*;

    logic [EPSW-1:0] r_eps;
    t_vec            pos, dir;
    logic            q_valid, q_pop, en;
    t_ray            q_data;
    t_dots           dots;
    t_quot           quot;
    t_coord          u, v, t;
    logic signed [CW:0] u_ext, v_ext, uv;
    t_result         res;
    t_result         r_obuf [ODEPTH];
    logic            r_owr, r_ord;
    logic [1:0]      r_ocnt;
    logic            opush, opop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_det_epsilon;
        end
    end

    assign pos = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
    assign dir = '{x: i_dir_x, y: i_dir_y, z: i_dir_z};

    // The whole back pipeline advances together unless a result cannot leave it.
    assign en    = !(quot.valid && (r_ocnt == 2'(ODEPTH)));
    assign q_pop = en && q_valid;

    rti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_vertex_slot (i_vertex_slot),
        .i_pos         (pos),
        .i_dir         (dir),
        .i_q_pop       (q_pop),
        .o_q_valid     (q_valid),
        .o_q_data      (q_data)
    );

    rti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_ray   (q_data),
        .o_dots  (dots)
    );

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_eps   (r_eps),
        .i_dots  (dots),
        .o_quot  (quot)
    );

    always_comb begin
        u     = from_mag(quot.neg[0], quot.qu);
        v     = from_mag(quot.neg[1], quot.qv);
        t     = from_mag(quot.neg[2], quot.qt);
        u_ext = {u[CW-1], u};
        v_ext = {v[CW-1], v};
        uv    = u_ext + v_ext;
        res.hit = quot.ok && !u[CW-1] && (u_ext <= ONE) && !v[CW-1] && (uv <= ONE);
        res.distance = res.hit ? t : '0;
    end

    assign opush = quot.valid && en;
    assign opop  = pop && !empty;
    assign empty = (r_ocnt == 2'd0);
    assign o_hit      = r_obuf[r_ord].hit;
    assign o_distance = r_obuf[r_ord].distance;

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_obuf[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush) begin
                r_owr <= ~r_owr;
            end
            if (opop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(opush) - 2'(opop);
        end
    end

`include "ray_triangle_intersect_assert.svh"

    `RTI_ASSERT_NOW(a_miss_zero, !empty && !o_hit, o_distance == '0, "miss with nonzero distance")
    `RTI_ASSERT_NEXT(a_stall_holds, !en, quot.valid && $stable(quot), "stalled result changed")
    `RTI_ASSERT_NEXT(a_full_stays, r_ocnt == 2'(ODEPTH) && !pop, r_ocnt == 2'(ODEPTH),
        "result buffer lost an entry")

endmodule
`default_nettype wire
